// ===== rtl/pen_stroke_segmenter_unit_macros.svh =====
// Assertion macros for the pen stroke segmenter
`ifndef PEN_STROKE_SEGMENTER_UNIT_MACROS_SVH
`define PEN_STROKE_SEGMENTER_UNIT_MACROS_SVH

// same-cycle implication
`define PSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pss assertion failed");

// next-cycle implication
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pss assertion failed");

`endif

// ===== rtl/pss_pkg.sv =====
`default_nettype none
package pss_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned PRES_W  = 16;
	localparam int unsigned PER_W   = 16;
	localparam int unsigned FLAG_W  = 3;
	localparam int unsigned IN_W    = 112;
	localparam int unsigned REC_W   = 152;
	localparam int unsigned NBYTES  = 19;
	localparam int unsigned MEAN_BYTE = 16;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned CNT_W   = 5;

	localparam logic [PER_W-1:0] PERIOD_RST = 16'd20;
	localparam logic [7:0]       CRC_POLY   = 8'h07;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD
	} pss_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pss_stat_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pen_stroke_segmenter_unit.sv =====
// Pen stroke segmenter.
// s_axis: one pen sample per beat. tdata holds sample_time_ms, delta_x_um,
// delta_y_um, pressure_mn from bit 0 up; tuser[0] is pen_is_down.
// m_axis: one segment per beat. tdata holds sequence_number, relative_time_ms,
// sum_dx_um, sum_dy_um, mean_pressure_mn, record_crc; tuser holds
// flag_pen_down, flag_stroke_start, flag_stroke_end.
// cfg: segment_period_ms, written whenever cfg_valid is high (cfg_ready is
// tied high); write it only while the block is idle.
// A sample that yields no segment is absorbed and the block stays idle. A
// sample that yields a segment passes from accept through the divider for
// the mean pressure, then the last three CRC bytes and the output load, to
// m_axis_tvalid; s_axis_tready is low meanwhile.
// The output register holds a segment until taken, and samples are accepted
// while it waits; a further segment waits in the load step until the
// output register frees.
// Reset clears control state, sets the period to 20 ms and empties the output.
`default_nettype none
module pen_stroke_segmenter_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// time[31:0], dx[63:32], dy[95:64], pressure[111:96]
	input  wire logic [111:0]  s_axis_tdata,
	// pen_is_down[0]
	input  wire logic [0:0]    s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// seq[31:0], rel time[63:32], sum dx[95:64], sum dy[127:96],
	// mean pressure[143:128], crc[151:144]
	output logic [151:0]       m_axis_tdata,
	// in_stroke[0], stroke_start[1], stroke_end[2]
	output logic [2:0]         m_axis_tuser,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [15:0]   cfg_data
);

	localparam int unsigned W = pss_pkg::WORD_W;

	pss_pkg::pss_state_t state_q, state_n;

	logic [pss_pkg::PER_W-1:0]   period_q;
	logic [W-1:0]                start_q, last_flush_q, next_seq_q;
	logic [W-1:0]                dx_acc_q, dy_acc_q, psum_q, count_q;
	logic                        in_stroke_q, fsp_q, prev_pen_q;

	logic [W-1:0]                rec_seq_q, rec_rel_q, rec_dx_q, rec_dy_q;
	logic [pss_pkg::FLAG_W-1:0]  rec_flags_q;
	logic                        rec_zero_q;

	logic                        out_valid_q;
	logic [pss_pkg::REC_W-1:0]   out_data_q;
	logic [pss_pkg::FLAG_W-1:0]  out_user_q;

	logic [W-1:0]                ts, dx, dy, start_n, dx_n, dy_n, psum_n, count_n, elapsed;
	logic [pss_pkg::PRES_W-1:0]  pres, mean;
	logic                        pen, rise, fall, timed, emit, accept;
	logic                        in_stroke_n, fsp_n;
	logic                        take, out_free, load, calc_done;

	pss_pkg::pss_stat_t          div_stat, crc_stat;
	logic [W-1:0]                quotient;
	logic [7:0]                  crc;
	logic [pss_pkg::REC_W-1:0]   rec;

	always_comb begin
		ts      = s_axis_tdata[31:0];
		dx      = s_axis_tdata[63:32];
		dy      = s_axis_tdata[95:64];
		pres    = s_axis_tdata[111:96];
		pen     = s_axis_tuser[0];
		start_n = (start_q == '0) ? ts : start_q;
		rise    = pen && !prev_pen_q;
		fall    = !pen && prev_pen_q;
		in_stroke_n = rise ? 1'b1 : (fall ? 1'b0 : in_stroke_q);
		fsp_n   = rise ? 1'b1 : fsp_q;
		dx_n    = pen ? dx_acc_q + dx : dx_acc_q;
		dy_n    = pen ? dy_acc_q + dy : dy_acc_q;
		psum_n  = pen ? psum_q + {{(W-pss_pkg::PRES_W){1'b0}}, pres} : psum_q;
		count_n = pen ? count_q + 1'b1 : count_q;
		elapsed = ts - last_flush_q;
		timed   = (elapsed >= {{(W-pss_pkg::PER_W){1'b0}}, period_q});
		emit    = fall || (timed && (count_n != '0));
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		case (state_q)
			pss_pkg::ST_IDLE: if (accept && emit) state_n = pss_pkg::ST_CALC;
			pss_pkg::ST_CALC: if (calc_done) state_n = pss_pkg::ST_LOAD;
			pss_pkg::ST_LOAD: if (out_free) state_n = pss_pkg::ST_IDLE;
			default:          state_n = pss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		load          = 1'b0;
		case (state_q)
			pss_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pss_pkg::ST_LOAD: load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		accept    = s_axis_tvalid && s_axis_tready;
		take      = out_valid_q && m_axis_tready;
		out_free  = !out_valid_q || m_axis_tready;
		calc_done = div_stat.done && !div_stat.busy && crc_stat.done && !crc_stat.busy;
		mean      = rec_zero_q ? '0 : quotient[pss_pkg::PRES_W-1:0];
		rec       = {5'b0, rec_flags_q, mean, rec_dy_q, rec_dx_q, rec_rel_q, rec_seq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pss_pkg::ST_IDLE;
			period_q     <= pss_pkg::PERIOD_RST;
			start_q      <= '0;
			last_flush_q <= '0;
			next_seq_q   <= '0;
			dx_acc_q     <= '0;
			dy_acc_q     <= '0;
			psum_q       <= '0;
			count_q      <= '0;
			in_stroke_q  <= 1'b0;
			fsp_q        <= 1'b0;
			prev_pen_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (accept) begin
				start_q     <= start_n;
				in_stroke_q <= in_stroke_n;
				prev_pen_q  <= pen;
				if (fall || timed) begin
					last_flush_q <= ts;
				end
				if (emit) begin
					next_seq_q <= next_seq_q + 1'b1;
					dx_acc_q   <= '0;
					dy_acc_q   <= '0;
					psum_q     <= '0;
					count_q    <= '0;
					fsp_q      <= 1'b0;
				end else begin
					dx_acc_q   <= dx_n;
					dy_acc_q   <= dy_n;
					psum_q     <= psum_n;
					count_q    <= count_n;
					fsp_q      <= fsp_n;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rec_seq_q   <= next_seq_q;
			rec_rel_q   <= ts - start_n;
			rec_dx_q    <= dx_n;
			rec_dy_q    <= dy_n;
			rec_flags_q <= {fall, fsp_n, in_stroke_n};
			rec_zero_q  <= (count_n == '0);
		end
		if (load) begin
			out_data_q <= {crc, mean, rec_dy_q, rec_dx_q, rec_rel_q, rec_seq_q};
			out_user_q <= rec_flags_q;
		end
	end

	pss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && emit),
		.dividend (psum_n),
		.divisor  (count_n),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// runs beside the divider, holds before the mean bytes until it is done
	pss_crc u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && emit),
		.mean_ok (div_stat.done),
		.rec     (rec),
		.stat    (crc_stat),
		.crc     (crc)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire

// ===== rtl/pss_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module pss_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pss_pkg::WORD_W-1:0]    dividend,
	input  wire logic [pss_pkg::WORD_W-1:0]    divisor,
	output pss_pkg::pss_stat_t                 stat,
	output logic      [pss_pkg::WORD_W-1:0]    quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [pss_pkg::CNT_W-1:0]     cnt_q;
	logic [pss_pkg::WORD_W-1:0]    rem_q;
	logic [pss_pkg::WORD_W-1:0]    quo_q;
	logic [pss_pkg::WORD_W-1:0]    den_q;
	logic [pss_pkg::WORD_W:0]      shifted;
	logic [pss_pkg::WORD_W:0]      trial;
	logic                          ge;

	always_comb begin
		shifted = {rem_q, quo_q[pss_pkg::WORD_W-1]};
		trial   = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[pss_pkg::WORD_W-1:0] : shifted[pss_pkg::WORD_W-1:0];
			quo_q <= {quo_q[pss_pkg::WORD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/pss_crc.sv =====
`default_nettype none
// bytewise CRC-8 over the record, waits for the mean before its bytes
module pss_crc (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         mean_ok,
	input  wire logic [pss_pkg::REC_W-1:0]    rec,
	output pss_pkg::pss_stat_t                stat,
	output logic      [7:0]                   crc
);

	logic                         busy_q;
	logic                         done_q;
	logic [pss_pkg::IDX_W-1:0]    idx_q;
	logic [7:0]                   crc_q;
	logic [7:0]                   cur_byte;
	logic                         step;

	always_comb begin
		cur_byte = rec[{idx_q, 3'b000} +: 8];
		step     = busy_q && ((idx_q < pss_pkg::IDX_W'(pss_pkg::MEAN_BYTE)) || mean_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (step) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == pss_pkg::IDX_W'(pss_pkg::NBYTES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= '0;
		end else if (step) begin
			crc_q <= pss_pkg::crc8_byte(crc_q, cur_byte);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign crc       = crc_q;

endmodule
`default_nettype wire

// ===== rtl/pss_checker.sv =====
`default_nettype none
`include "pen_stroke_segmenter_unit_macros.svh"
module pss_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          m_axis_tvalid,
	input wire logic          m_axis_tready,
	input wire logic [151:0]  m_axis_tdata,
	input wire logic [2:0]    m_axis_tuser
);

	`PSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`PSS_ASSERT_NOW(a_end_not_down, m_axis_tvalid && m_axis_tuser[2], !m_axis_tuser[0])
	`PSS_ASSERT_NOW(a_start_in_stroke, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] || m_axis_tuser[2])
	`PSS_ASSERT_NOW(a_reset_empty, $rose(arst_n), !m_axis_tvalid)

endmodule

bind pen_stroke_segmenter_unit pss_checker u_pss_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 120;
	localparam int IDLE_PCT     = 18;
	localparam int NOISE_PCT    = 15;
	localparam int QUIET_PHASE  = 3;
	localparam int PAUSE_PHASE  = 5;
	localparam int HOLD_AT      = 680;
	localparam int HOLD_CYCLES  = 600;
	localparam int STALL_LIMIT  = 4000;
	localparam int PRINT_LIMIT  = 30;

	localparam logic [2:0] FLAG_IN_STROKE = 3'b001;
	localparam logic [2:0] FLAG_START     = 3'b010;
	localparam logic [2:0] FLAG_END       = 3'b100;

	typedef enum logic {ROW_SAMPLE, ROW_PERIOD} row_kind_t;

	typedef struct packed {
		logic [31:0] ts;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [15:0] pres;
		logic        pen;
	} sample_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] rel;
		logic [31:0] sdx;
		logic [31:0] sdy;
		logic [15:0] mean;
		logic [2:0]  flags;
		logic [7:0]  crc;
	} segment_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] period;
		sample_t     smp;
		logic        typed;
		segment_t    want;
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [111:0]  s_axis_tdata = '0;
	logic [0:0]    s_axis_tuser = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [151:0]  m_axis_tdata;
	logic [2:0]    m_axis_tuser;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [15:0]   cfg_data = '0;

	// travels with the input beat: a hand-typed expectation, if any
	logic          note_typed = 1'b0;
	segment_t      note_want = '0;

	// segmenter state as the block should hold it
	logic [15:0]   flush_period = pss_pkg::PERIOD_RST;
	logic [31:0]   sess_start = '0;
	logic [31:0]   last_flush = '0;
	logic [31:0]   seq_next = '0;
	logic [31:0]   acc_dx = '0;
	logic [31:0]   acc_dy = '0;
	logic [31:0]   psum = '0;
	logic [31:0]   nsamp = '0;
	logic          in_stroke = 1'b0;
	logic          start_pending = 1'b0;
	logic          pen_prev = 1'b0;

	segment_t      segments_due[$];

	int            faults = 0;
	int            samples_in = 0;
	int            segments_seen = 0;
	int            period_writes = 0;
	int            stall_cycles = 0;
	logic          quiet = 1'b0;
	logic          held_off = 1'b0;

	sample_t       smp_seen;
	segment_t      seg_got;
	segment_t      seg_want;
	segment_t      seg_pred;
	logic          pred_made;

	pen_stroke_segmenter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [7:0] record_crc8(input segment_t s);
		logic [151:0] rec;
		logic [7:0]   c;
		rec = {5'b0, s.flags, s.mean, s.sdy, s.sdx, s.rel, s.seq};
		c = 8'h00;
		for (int i = 0; i < pss_pkg::NBYTES; i++) begin
			c = c ^ rec[8*i +: 8];
			for (int k = 0; k < 8; k++)
				c = c[7] ? ((c << 1) ^ pss_pkg::CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic void close_segment(input logic [31:0] now, input logic at_end,
			output logic made, output segment_t seg);
		logic [31:0] quot;
		seg = '0;
		made = 1'b0;
		if (nsamp == 0 && !at_end)
			return;
		made = 1'b1;
		seg.seq = seq_next;
		seq_next = seq_next + 1;
		seg.rel = now - sess_start;
		seg.sdx = acc_dx;
		seg.sdy = acc_dy;
		if (nsamp != 0) begin
			quot = psum / nsamp;
			seg.mean = quot[15:0];
		end
		seg.flags = {at_end, start_pending, in_stroke};
		seg.crc = record_crc8(seg);
		acc_dx = '0;
		acc_dy = '0;
		psum = '0;
		nsamp = '0;
		start_pending = 1'b0;
	endfunction

	function automatic void fold_sample(input sample_t s, output logic made,
			output segment_t seg);
		logic [31:0] elapsed;
		made = 1'b0;
		seg = '0;
		// a start time of zero reads as unset
		if (sess_start == 0)
			sess_start = s.ts;
		if (s.pen && !pen_prev) begin
			in_stroke = 1'b1;
			start_pending = 1'b1;
		end
		// pen lift: end segment, sample itself dropped
		if (!s.pen && pen_prev) begin
			in_stroke = 1'b0;
			close_segment(s.ts, 1'b1, made, seg);
			pen_prev = 1'b0;
			last_flush = s.ts;
			return;
		end
		pen_prev = s.pen;
		if (s.pen) begin
			acc_dx = acc_dx + s.dx;
			acc_dy = acc_dy + s.dy;
			psum = psum + s.pres;
			nsamp = nsamp + 1;
		end
		elapsed = s.ts - last_flush;
		if (elapsed >= {16'h0, flush_period}) begin
			close_segment(s.ts, 1'b0, made, seg);
			last_flush = s.ts;
		end
	endfunction

	task automatic log_fault(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (faults < PRINT_LIMIT)
			$display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
		faults++;
	endtask

	function automatic row_t sample_row(input logic [31:0] ts, dx, dy,
			input logic [15:0] pres, input logic pen);
		row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp.ts = ts;
		r.smp.dx = dx;
		r.smp.dy = dy;
		r.smp.pres = pres;
		r.smp.pen = pen;
		return r;
	endfunction

	function automatic row_t segment_row(input logic [31:0] ts, dx, dy,
			input logic [15:0] pres, input logic pen,
			input logic [31:0] seq, rel, sdx, sdy,
			input logic [15:0] mean, input logic [2:0] flags);
		row_t r;
		r = sample_row(ts, dx, dy, pres, pen);
		r.typed = 1'b1;
		r.want.seq = seq;
		r.want.rel = rel;
		r.want.sdx = sdx;
		r.want.sdy = sdy;
		r.want.mean = mean;
		r.want.flags = flags;
		return r;
	endfunction

	function automatic row_t period_row(input logic [15:0] v);
		row_t r;
		r = '0;
		r.kind = ROW_PERIOD;
		r.period = v;
		return r;
	endfunction

	task automatic put_sample(input sample_t s, input logic typed, input segment_t want);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {s.pres, s.dy, s.dx, s.ts};
		s_axis_tuser <= s.pen;
		note_typed <= typed;
		note_want <= want;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (segments_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_period(input logic [15:0] v);
		wait_drained();
		// a beat with no segment may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seg_got.seq = m_axis_tdata[31:0];
				seg_got.rel = m_axis_tdata[63:32];
				seg_got.sdx = m_axis_tdata[95:64];
				seg_got.sdy = m_axis_tdata[127:96];
				seg_got.mean = m_axis_tdata[143:128];
				seg_got.crc = m_axis_tdata[151:144];
				seg_got.flags = m_axis_tuser;
				segments_seen++;
				if (segments_due.size() == 0) begin
					log_fault("segment with none due", seg_got.seq, '0);
				end else begin
					seg_want = segments_due.pop_front();
					if (seg_got.seq != seg_want.seq)
						log_fault("sequence_number", seg_got.seq, seg_want.seq);
					if (seg_got.rel != seg_want.rel)
						log_fault("relative_time_ms", seg_got.rel, seg_want.rel);
					if (seg_got.sdx != seg_want.sdx)
						log_fault("sum_dx_um", seg_got.sdx, seg_want.sdx);
					if (seg_got.sdy != seg_want.sdy)
						log_fault("sum_dy_um", seg_got.sdy, seg_want.sdy);
					if (seg_got.mean != seg_want.mean)
						log_fault("mean_pressure_mn", seg_got.mean, seg_want.mean);
					if (seg_got.flags[0] != seg_want.flags[0])
						log_fault("in-stroke flag", seg_got.flags[0], seg_want.flags[0]);
					if (seg_got.flags[1] != seg_want.flags[1])
						log_fault("flag_stroke_start", seg_got.flags[1], seg_want.flags[1]);
					if (seg_got.flags[2] != seg_want.flags[2])
						log_fault("flag_stroke_end", seg_got.flags[2], seg_want.flags[2]);
					if (seg_got.crc != seg_want.crc)
						log_fault("record_crc", seg_got.crc, seg_want.crc);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				smp_seen.ts = s_axis_tdata[31:0];
				smp_seen.dx = s_axis_tdata[63:32];
				smp_seen.dy = s_axis_tdata[95:64];
				smp_seen.pres = s_axis_tdata[111:96];
				smp_seen.pen = s_axis_tuser[0];
				samples_in++;
				fold_sample(smp_seen, pred_made, seg_pred);
				if (note_typed) begin
					seg_pred = note_want;
					seg_pred.crc = record_crc8(seg_pred);
					segments_due.push_back(seg_pred);
				end else if (pred_made) begin
					segments_due.push_back(seg_pred);
				end
			end
			if (cfg_valid && cfg_ready) begin
				flush_period = cfg_data;
				period_writes++;
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
					(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// output side: random back-pressure, one long hold-off mid-run
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && !held_off && samples_in >= HOLD_AT) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("no beat moved for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t        plan[$];
		sample_t     smp;
		logic [15:0] per;
		logic [31:0] clock_ms;
		logic        pen_level;
		int          run_left;

		clock_ms = 32'd100000;
		pen_level = 1'b0;
		run_left = 0;

		// session start stays unset on a zero time
		plan.push_back(sample_row(32'd0, 32'h12345678, 32'hEDCBA987, 16'h1234, 1'b0));
		plan.push_back(sample_row(32'd5, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1));
		plan.push_back(sample_row(32'd10, 32'd1, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
		plan.push_back(segment_row(32'd25, 32'd0, 32'd0, 16'd0, 1'b1,
			32'd0, 32'd20, 32'h80000000, 32'h7FFFFFFF, 16'hAAAA, FLAG_IN_STROKE | FLAG_START));
		// empty end segment
		plan.push_back(segment_row(32'd30, 32'h55, 32'h66, 16'h77, 1'b0,
			32'd1, 32'd25, 32'd0, 32'd0, 16'd0, FLAG_END));
		// timed flush with nothing gathered
		plan.push_back(sample_row(32'd60, 32'd0, 32'd0, 16'd0, 1'b0));
		plan.push_back(period_row(16'd0));
		plan.push_back(segment_row(32'd61, 32'hFFFFFFFB, 32'd3, 16'd100, 1'b1,
			32'd2, 32'd56, 32'hFFFFFFFB, 32'd3, 16'd100, FLAG_IN_STROKE | FLAG_START));
		plan.push_back(segment_row(32'd61, 32'd2, 32'd2, 16'd7, 1'b1,
			32'd3, 32'd56, 32'd2, 32'd2, 16'd7, FLAG_IN_STROKE));
		plan.push_back(period_row(16'hFFFF));
		plan.push_back(sample_row(32'd100, 32'd10, 32'd20, 16'd1, 1'b1));
		// time running backwards
		plan.push_back(segment_row(32'd40, 32'd0, 32'd0, 16'd0, 1'b1,
			32'd4, 32'd35, 32'd10, 32'd20, 16'd0, FLAG_IN_STROKE));
		plan.push_back(segment_row(32'hFFFFFFFF, 32'd9, 32'd9, 16'd9, 1'b0,
			32'd5, 32'hFFFFFFFA, 32'd0, 32'd0, 16'd0, FLAG_END));
		plan.push_back(sample_row(32'd3, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b1));
		plan.push_back(segment_row(32'd4, 32'd0, 32'd0, 16'd0, 1'b0,
			32'd6, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, FLAG_START | FLAG_END));
		plan.push_back(period_row(16'd1));
		plan.push_back(sample_row(32'd4, 32'd1, 32'd0, 16'd9, 1'b1));
		plan.push_back(segment_row(32'd5, 32'd0, 32'd1, 16'd10, 1'b1,
			32'd7, 32'd0, 32'd1, 32'd1, 16'd9, FLAG_IN_STROKE | FLAG_START));
		plan.push_back(sample_row(32'd5, 32'd3, 32'd4, 16'd2, 1'b1));
		plan.push_back(segment_row(32'd5, 32'd0, 32'd0, 16'd0, 1'b0,
			32'd8, 32'd0, 32'd3, 32'd4, 16'd2, FLAG_END));

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_PERIOD)
				set_period(plan[r].period);
			else
				put_sample(plan[r].smp, plan[r].typed, plan[r].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: per = 16'd1;
				1: per = 16'hFFFF;
				2: per = 16'd0;
				default: begin
					case ($urandom_range(0, 3))
						0, 1: per = 16'($urandom_range(2, 40));
						2: per = 16'($urandom_range(41, 600));
						default: per = 16'($urandom_range(0, 65535));
					endcase
				end
			endcase
			set_period(per);
			quiet = (ph == QUIET_PHASE);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == PAUSE_PHASE && i == PHASE_ITEMS / 2)
					wait_drained();
				if ($urandom_range(0, 99) < NOISE_PCT) begin
					clock_ms = $urandom;
					smp.pen = 1'($urandom_range(0, 1));
				end else begin
					// strokes: runs of pen-down beats between short lifts
					clock_ms = clock_ms + $urandom_range(0, 12);
					if (run_left == 0) begin
						pen_level = !pen_level;
						run_left = pen_level ? $urandom_range(2, 30) : $urandom_range(1, 4);
					end
					run_left--;
					smp.pen = pen_level;
				end
				smp.ts = clock_ms;
				smp.dx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400) - 200;
				smp.dy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400) - 200;
				smp.pres = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, 2000));
				put_sample(smp, 1'b0, '0);
			end
			quiet = 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d pen samples in, %0d segments compared, %0d period writes (0, 1, 65535 incl.)",
			samples_in, segments_seen, period_writes);
		$display("strokes, noise, time wrap, long output stall and mid-run drain; %0d faults",
			faults);
		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
